// ===== rtl/hrht_pkg.sv =====
// Shared constants, types and helpers for the HTTP request header tokenizer.
package hrht_pkg;

    localparam int MAX_HEADERS = 32;
    localparam int KEY_LEN     = 64;
    localparam int VALUE_LEN   = 256;
    localparam int TOKEN_LEN   = 16;

    localparam int LEN_MAX = (VALUE_LEN > KEY_LEN)
        ? ((VALUE_LEN > TOKEN_LEN) ? VALUE_LEN : TOKEN_LEN)
        : ((KEY_LEN > TOKEN_LEN) ? KEY_LEN : TOKEN_LEN);
    // length may sit one above the largest cap once truncated
    localparam int LEN_W  = $clog2(LEN_MAX + 1);
    localparam int HC_W   = $clog2(MAX_HEADERS + 1);
    localparam int LIM_W  = 7;
    localparam int CFG_W  = 6;
    localparam int IDX_W  = 5;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [2:0] KIND_METHOD  = 3'd0;
    localparam logic [2:0] KIND_PATH    = 3'd1;
    localparam logic [2:0] KIND_VERSION = 3'd2;
    localparam logic [2:0] KIND_KEY     = 3'd3;
    localparam logic [2:0] KIND_VALUE   = 3'd4;
    localparam logic [2:0] KIND_BODY    = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TRUNC   = 2'd1;
    localparam logic [1:0] ST_DROP    = 2'd2;
    localparam logic [1:0] ST_NOCOLON = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       eor;
        logic       is_cr;
        logic       is_lf;
        logic       is_sp;
        logic       is_colon;
    } item_t;

    function automatic logic [LEN_W-1:0] cap_of(input logic [2:0] kind);
        logic [LEN_W-1:0] cap;
        case (kind)
            KIND_METHOD, KIND_VERSION: cap = LEN_W'(TOKEN_LEN - 1);
            KIND_KEY:                  cap = LEN_W'(KEY_LEN - 1);
            default:                   cap = LEN_W'(VALUE_LEN - 1);
        endcase
        return cap;
    endfunction

endpackage

// ===== rtl/hrht_front.sv =====
// Front end: takes request bytes and classifies the delimiters.
module hrht_front (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 s_tlast,
    input  logic                 q_full,
    output logic                 q_push,
    output hrht_pkg::item_t      q_item
);

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb
    begin
        q_item.data_byte = s_tdata;
        q_item.eor       = s_tlast;
        q_item.is_cr     = (s_tdata == hrht_pkg::CH_CR);
        q_item.is_lf     = (s_tdata == hrht_pkg::CH_LF);
        q_item.is_sp     = (s_tdata == hrht_pkg::CH_SP);
        q_item.is_colon  = (s_tdata == hrht_pkg::CH_COLON);
    end

endmodule

// ===== rtl/hrht_fifo.sv =====
// Short queue of classified bytes between front and back end.
module hrht_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  hrht_pkg::item_t      push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output hrht_pkg::item_t      head
);

    hrht_pkg::item_t                   mem_reg [hrht_pkg::FIFO_DEPTH];
    logic [hrht_pkg::FIFO_AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [hrht_pkg::FIFO_AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [hrht_pkg::FIFO_CW-1:0]      count_reg, count_next;

    assign full      = (count_reg == hrht_pkg::FIFO_CW'(hrht_pkg::FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/hrht_back.sv =====
// Back end: parse state machine and registered result stage.
module hrht_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [hrht_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                        q_not_empty,
    input  hrht_pkg::item_t             q_head,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,
    output logic                        m_tlast,
    output logic [5:0]                  m_tuser
);

    typedef enum logic [2:0] {
        PH_METHOD  = 3'd0,
        PH_PATH    = 3'd1,
        PH_VERSION = 3'd2,
        PH_KEY     = 3'd3,
        PH_VALUE   = 3'd4,
        PH_BODY    = 3'd5,
        PH_DISCARD = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        TRK_NONE = 2'd0,
        TRK_CR   = 2'd1,
        TRK_LF   = 2'd2
    } trk_t;

    phase_t                            phase_reg, phase_next;
    logic [hrht_pkg::LEN_W-1:0]        len_reg, len_next;
    logic [hrht_pkg::HC_W-1:0]         hc_reg, hc_next;
    trk_t                              trk_reg, trk_next;
    logic                              skip_reg, skip_next;
    logic [hrht_pkg::CFG_W-1:0]        limit_reg;

    logic                              out_valid_reg, out_valid_next;
    logic [7:0]                        out_byte_reg, out_byte_next;
    logic                              byte_valid_reg, byte_valid_next;
    logic [2:0]                        kind_reg, kind_next;
    logic [hrht_pkg::IDX_W-1:0]        idx_reg, idx_next;
    logic                              end_reg, end_next;
    logic [1:0]                        status_reg, status_next;

    logic                              have;
    logic                              do_content;
    logic                              brk;
    trk_t                              brk_trk;
    logic [hrht_pkg::LIM_W-1:0]        lim;
    logic [hrht_pkg::LEN_W-1:0]        cap;
    logic [hrht_pkg::IDX_W-1:0]        cur_idx;

    assign q_pop = q_not_empty && (!out_valid_reg || m_tready);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, idx_reg, out_byte_reg};
    assign m_tlast  = end_reg;
    assign m_tuser  = {status_reg, kind_reg, byte_valid_reg};

    always_comb
    begin
        phase_next      = phase_reg;
        len_next        = len_reg;
        hc_next         = hc_reg;
        trk_next        = trk_reg;
        skip_next       = skip_reg;
        have            = 1'b0;
        do_content      = 1'b0;
        out_byte_next   = 8'h00;
        byte_valid_next = 1'b0;
        kind_next       = 3'(phase_reg);
        idx_next        = '0;
        end_next        = 1'b0;
        status_next     = hrht_pkg::ST_OK;
        cap             = '0;
        cur_idx         = '0;

        brk     = q_head.is_cr || q_head.is_lf;
        brk_trk = q_head.is_cr ? TRK_CR : TRK_LF;
        lim     = (hrht_pkg::LIM_W'(limit_reg) > hrht_pkg::LIM_W'(hrht_pkg::MAX_HEADERS))
                  ? hrht_pkg::LIM_W'(hrht_pkg::MAX_HEADERS)
                  : hrht_pkg::LIM_W'(limit_reg);

        if (trk_reg == TRK_CR && q_head.is_lf)
        begin
            trk_next = (phase_reg == PH_BODY) ? TRK_NONE : TRK_LF;
        end
        else if (phase_reg == PH_METHOD || phase_reg == PH_PATH || phase_reg == PH_VERSION)
        begin
            if (q_head.is_sp)
            begin
                if (len_reg != '0)
                begin
                    have       = 1'b1;
                    kind_next  = 3'(phase_reg);
                    end_next   = 1'b1;
                    phase_next = (phase_reg == PH_VERSION) ? PH_DISCARD
                                 : phase_t'(phase_reg + 3'd1);
                    len_next   = '0;
                end
            end
            else if (brk)
            begin
                if (!(phase_reg == PH_METHOD && len_reg == '0))
                begin
                    if (len_reg != '0)
                    begin
                        have      = 1'b1;
                        kind_next = 3'(phase_reg);
                        end_next  = 1'b1;
                    end
                    phase_next = PH_KEY;
                    len_next   = '0;
                    trk_next   = brk_trk;
                end
            end
            else
            begin
                do_content = 1'b1;
            end
        end
        else if (phase_reg == PH_KEY)
        begin
            if (brk)
            begin
                if (len_reg == '0)
                begin
                    // blank line: headers done
                    phase_next = PH_BODY;
                    trk_next   = q_head.is_cr ? TRK_CR : TRK_NONE;
                end
                else
                begin
                    have        = 1'b1;
                    kind_next   = hrht_pkg::KIND_KEY;
                    idx_next    = hrht_pkg::IDX_W'(hc_reg);
                    end_next    = 1'b1;
                    status_next = hrht_pkg::ST_NOCOLON;
                    len_next    = '0;
                    trk_next    = brk_trk;
                end
            end
            else
            begin
                trk_next = TRK_NONE;
                if (len_reg == '0 && hrht_pkg::LIM_W'(hc_reg) >= lim)
                begin
                    have        = 1'b1;
                    kind_next   = hrht_pkg::KIND_KEY;
                    end_next    = 1'b1;
                    status_next = hrht_pkg::ST_DROP;
                    phase_next  = PH_DISCARD;
                end
                else if (q_head.is_colon)
                begin
                    have       = 1'b1;
                    kind_next  = hrht_pkg::KIND_KEY;
                    idx_next   = hrht_pkg::IDX_W'(hc_reg);
                    end_next   = 1'b1;
                    phase_next = PH_VALUE;
                    len_next   = '0;
                    skip_next  = 1'b1;
                end
                else
                begin
                    do_content = 1'b1;
                end
            end
        end
        else if (phase_reg == PH_VALUE)
        begin
            if (brk)
            begin
                have       = 1'b1;
                kind_next  = hrht_pkg::KIND_VALUE;
                idx_next   = hrht_pkg::IDX_W'(hc_reg);
                end_next   = 1'b1;
                hc_next    = hc_reg + 1'b1;
                phase_next = PH_KEY;
                len_next   = '0;
                skip_next  = 1'b0;
                trk_next   = brk_trk;
            end
            else
            begin
                trk_next = TRK_NONE;
                if (!(skip_reg && q_head.is_sp))
                begin
                    skip_next  = 1'b0;
                    do_content = 1'b1;
                end
            end
        end
        else if (phase_reg == PH_BODY)
        begin
            trk_next        = TRK_NONE;
            have            = 1'b1;
            out_byte_next   = q_head.data_byte;
            byte_valid_next = 1'b1;
            kind_next       = hrht_pkg::KIND_BODY;
        end
        else
        begin
            // discard to end of line
            if (brk)
            begin
                phase_next = PH_KEY;
                len_next   = '0;
                trk_next   = brk_trk;
            end
            else
            begin
                trk_next = TRK_NONE;
            end
        end

        if (do_content)
        begin
            cap     = hrht_pkg::cap_of(3'(phase_reg));
            cur_idx = (phase_reg == PH_KEY || phase_reg == PH_VALUE)
                      ? hrht_pkg::IDX_W'(hc_reg) : '0;
            if (len_reg < cap)
            begin
                have            = 1'b1;
                out_byte_next   = q_head.data_byte;
                byte_valid_next = 1'b1;
                kind_next       = 3'(phase_reg);
                idx_next        = cur_idx;
                len_next        = len_reg + 1'b1;
            end
            else if (len_reg == cap)
            begin
                have        = 1'b1;
                kind_next   = 3'(phase_reg);
                idx_next    = cur_idx;
                status_next = hrht_pkg::ST_TRUNC;
                len_next    = len_reg + 1'b1;
            end
        end

        if (q_head.eor)
        begin
            if (have)
            begin
                if (!end_next && kind_next == hrht_pkg::KIND_KEY
                    && status_next == hrht_pkg::ST_OK)
                begin
                    status_next = hrht_pkg::ST_NOCOLON;
                end
                end_next = 1'b1;
            end
            else if (phase_next == PH_METHOD || phase_next == PH_PATH
                     || phase_next == PH_VERSION)
            begin
                if (len_next != '0)
                begin
                    have      = 1'b1;
                    kind_next = 3'(phase_next);
                    end_next  = 1'b1;
                end
            end
            else if (phase_next == PH_KEY)
            begin
                if (len_next != '0)
                begin
                    have        = 1'b1;
                    kind_next   = hrht_pkg::KIND_KEY;
                    idx_next    = hrht_pkg::IDX_W'(hc_next);
                    end_next    = 1'b1;
                    status_next = hrht_pkg::ST_NOCOLON;
                end
            end
            else if (phase_next == PH_VALUE)
            begin
                have      = 1'b1;
                kind_next = hrht_pkg::KIND_VALUE;
                idx_next  = hrht_pkg::IDX_W'(hc_next);
                end_next  = 1'b1;
            end
            else if (phase_next == PH_BODY)
            begin
                have      = 1'b1;
                kind_next = hrht_pkg::KIND_BODY;
                end_next  = 1'b1;
            end
            phase_next = PH_METHOD;
            len_next   = '0;
            hc_next    = '0;
            trk_next   = TRK_NONE;
            skip_next  = 1'b0;
        end

        if (q_pop)
        begin
            out_valid_next = have;
        end
        else
        begin
            out_valid_next = out_valid_reg && !m_tready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg      <= hrht_pkg::CFG_W'(32);
            phase_reg      <= PH_METHOD;
            len_reg        <= '0;
            hc_reg         <= '0;
            trk_reg        <= TRK_NONE;
            skip_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_byte_reg   <= '0;
            byte_valid_reg <= 1'b0;
            kind_reg       <= '0;
            idx_reg        <= '0;
            end_reg        <= 1'b0;
            status_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                phase_reg      <= phase_next;
                len_reg        <= len_next;
                hc_reg         <= hc_next;
                trk_reg        <= trk_next;
                skip_reg       <= skip_next;
                out_byte_reg   <= out_byte_next;
                byte_valid_reg <= byte_valid_next;
                kind_reg       <= kind_next;
                idx_reg        <= idx_next;
                end_reg        <= end_next;
                status_reg     <= status_next;
            end
        end
    end

    a_hc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hrht_pkg::LIM_W'(hc_reg) <= hrht_pkg::LIM_W'(hrht_pkg::MAX_HEADERS))
        else $error("header counter past limit");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= hrht_pkg::LEN_W'(hrht_pkg::LEN_MAX))
        else $error("field length past cap");

    a_byte_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && byte_valid_reg && status_reg != hrht_pkg::ST_OK)
        |-> (kind_reg == hrht_pkg::KIND_KEY && end_reg))
        else $error("content byte with bad status");

    a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg != hrht_pkg::KIND_KEY
         && kind_reg != hrht_pkg::KIND_VALUE) |-> (idx_reg == '0))
        else $error("header index outside header field");

    a_no_pop_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !q_pop)
        else $error("queue popped while result stalled");

endmodule

// ===== rtl/http_request_header_tokenizer.sv =====
// Top level of the HTTP request header tokenizer.
// Takes one request byte per cycle while the queue has room (tlast marks the final byte)
// and gives at most one result per byte: a content byte tagged with its field, or a field
// marker. Sustained rate is one byte per cycle while m_tready is high. A byte goes from the
// classifier into a four-entry queue, and the parse state machine pops it into its
// registered result stage, which lets input be taken while a result waits. Input is
// held off only once the queue holds four bytes. header_limit is written through
// cfg_we/cfg_wdata and resets to 32; no clearing pass is needed after reset.
module http_request_header_tokenizer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [hrht_pkg::CFG_W-1:0]  cfg_wdata,   // header_limit
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,     // [7:0] data_byte
    input  logic                        s_tlast,     // end_of_request
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,     // [7:0] out_byte, [12:8] header_index
    output logic                        m_tlast,     // field_end
    output logic [5:0]                  m_tuser      // [0] byte_valid, [3:1] field_kind,
                                                     // [5:4] status
);

    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_not_empty;
    hrht_pkg::item_t q_in;
    hrht_pkg::item_t q_head;

    hrht_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_in)
    );

    hrht_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    hrht_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule
